FILE: rtl/bra_pkg.sv
`timescale 1ns / 1ps

package bra_pkg;

    // Fixed sizes of the request, response and configuration fields, and the pool reset value.
    localparam int RES_SLOTS  = 3;
    localparam int TYPE_W     = 2;
    localparam int CUST_W     = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int POOL_RESET = 10;

    // Request type codes. Both upper codes reload the pools.
    localparam logic [TYPE_W-1:0] REQ_ALLOCATE    = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_RELEASE     = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RESTART     = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_RESTART_ALT = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_2 = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_GRANTED   = 3'd0,
        STAT_NEED      = 3'd1,
        STAT_AVAIL     = 3'd2,
        STAT_UNSAFE    = 3'd3,
        STAT_RELEASED  = 3'd4,
        STAT_RESTARTED = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOOKUP,
        ST_WALK_START,
        ST_WALK,
        ST_ROLLBACK,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    in_ready;
        logic    capture;
        logic    restart;
        logic    rd_cust;
        logic    release_apply;
        logic    tentative;
        logic    walk_init;
        logic    walk_step;
        logic    rollback;
        logic    load_out;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_restart;
        logic is_release;
        logic cust_ok;
        logic over_need;
        logic over_avail;
        logic walk_safe;
        logic walk_unsafe;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/bra_if.sv
`timescale 1ns / 1ps

interface bra_req_if #(
    parameter int AMOUNT_WIDTH = 8
);
    logic                          valid;
    logic                          ready;
    logic [bra_pkg::TYPE_W-1:0]    req_type;
    logic [bra_pkg::CUST_W-1:0]    customer;
    logic [AMOUNT_WIDTH-1:0]       amount_0;
    logic [AMOUNT_WIDTH-1:0]       amount_1;
    logic [AMOUNT_WIDTH-1:0]       amount_2;

    modport source (
        output valid, req_type, customer, amount_0, amount_1, amount_2,
        input  ready
    );
    modport sink (
        input  valid, req_type, customer, amount_0, amount_1, amount_2,
        output ready
    );
endinterface

interface bra_rsp_if #(
    parameter int AMOUNT_WIDTH = 8
);
    logic                          valid;
    logic                          ready;
    logic [bra_pkg::STATUS_W-1:0]  status;
    logic [AMOUNT_WIDTH-1:0]       avail_0;
    logic [AMOUNT_WIDTH-1:0]       avail_1;
    logic [AMOUNT_WIDTH-1:0]       avail_2;

    modport source (
        output valid, status, avail_0, avail_1, avail_2,
        input  ready
    );
    modport sink (
        input  valid, status, avail_0, avail_1, avail_2,
        output ready
    );
endinterface

FILE: rtl/bra_ctrl.sv
`timescale 1ns / 1ps

module bra_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  bra_pkg::t_dp_stat  i_stat,
    output bra_pkg::t_dp_cmd   o_cmd
);

    bra_pkg::t_state  r_state, n_state;
    bra_pkg::t_status r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bra_pkg::ST_IDLE;
            r_status <= bra_pkg::STAT_GRANTED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd        = '0;
        o_cmd.status = r_status;
        case (r_state)
            bra_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bra_pkg::ST_DECODE;
                end
            end
            bra_pkg::ST_DECODE: begin
                if (i_stat.is_restart) begin
                    o_cmd.restart = 1'b1;
                    n_status      = bra_pkg::STAT_RESTARTED;
                    n_state       = bra_pkg::ST_DONE;
                end else if (!i_stat.cust_ok) begin
                    n_status = i_stat.is_release ? bra_pkg::STAT_RELEASED
                                                 : bra_pkg::STAT_NEED;
                    n_state  = bra_pkg::ST_DONE;
                end else begin
                    o_cmd.rd_cust = 1'b1;
                    n_state       = bra_pkg::ST_LOOKUP;
                end
            end
            bra_pkg::ST_LOOKUP: begin
                if (i_stat.is_release) begin
                    o_cmd.release_apply = 1'b1;
                    n_status            = bra_pkg::STAT_RELEASED;
                    n_state             = bra_pkg::ST_DONE;
                end else if (i_stat.over_need) begin
                    n_status = bra_pkg::STAT_NEED;
                    n_state  = bra_pkg::ST_DONE;
                end else if (i_stat.over_avail) begin
                    n_status = bra_pkg::STAT_AVAIL;
                    n_state  = bra_pkg::ST_DONE;
                end else begin
                    o_cmd.tentative = 1'b1;
                    n_state         = bra_pkg::ST_WALK_START;
                end
            end
            bra_pkg::ST_WALK_START: begin
                o_cmd.walk_init = 1'b1;
                n_state         = bra_pkg::ST_WALK;
            end
            bra_pkg::ST_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_stat.walk_safe) begin
                    n_status = bra_pkg::STAT_GRANTED;
                    n_state  = bra_pkg::ST_DONE;
                end else if (i_stat.walk_unsafe) begin
                    n_state = bra_pkg::ST_ROLLBACK;
                end
            end
            bra_pkg::ST_ROLLBACK: begin
                o_cmd.rollback = 1'b1;
                n_status       = bra_pkg::STAT_UNSAFE;
                n_state        = bra_pkg::ST_DONE;
            end
            bra_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = bra_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bra_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/bra_dp.sv
`timescale 1ns / 1ps

module bra_dp #(
    parameter int NUM_CUSTOMERS = 5,
    parameter int NUM_RESOURCES = 3,
    parameter int AMOUNT_WIDTH  = 8
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    input  bra_pkg::t_dp_cmd                                   i_cmd,
    output bra_pkg::t_dp_stat                                  o_stat,
    input  logic [bra_pkg::TYPE_W-1:0]                         i_req_type,
    input  logic [bra_pkg::CUST_W-1:0]                         i_customer,
    input  logic [bra_pkg::RES_SLOTS-1:0][AMOUNT_WIDTH-1:0]    i_amount,
    input  logic                                               i_cfg_we,
    input  logic [bra_pkg::CFG_IDX_W-1:0]                      i_cfg_idx,
    input  logic [AMOUNT_WIDTH-1:0]                            i_cfg_data,
    input  logic                                               i_out_ready,
    output logic                                               o_out_valid,
    output logic [bra_pkg::STATUS_W-1:0]                       o_out_status,
    output logic [bra_pkg::RES_SLOTS-1:0][AMOUNT_WIDTH-1:0]    o_out_avail
);

    localparam int CIW = (NUM_CUSTOMERS > 1) ? $clog2(NUM_CUSTOMERS) : 1;
    localparam int WW  = AMOUNT_WIDTH + $clog2(NUM_CUSTOMERS + 1);

    typedef logic [bra_pkg::RES_SLOTS-1:0][AMOUNT_WIDTH-1:0] t_row;
    typedef logic [bra_pkg::RES_SLOTS-1:0][WW-1:0]           t_work;

    localparam logic [AMOUNT_WIDTH-1:0] AMT_MAX = '1;

    // Captured request.
    logic [bra_pkg::TYPE_W-1:0] r_type;
    logic [bra_pkg::CUST_W-1:0] r_cust;
    t_row                       r_amt;

    // Architectural state.
    t_row                       r_pool;
    t_row                       r_avail, n_avail;
    logic [NUM_CUSTOMERS-1:0]   r_valid;

    // Allocation memory, one row per customer.
    t_row                       mem [NUM_CUSTOMERS];
    t_row                       r_rd_row;
    logic                       r_rd_vld;
    t_row                       r_old_row;

    // Safety walk.
    t_work                      r_work;
    logic [NUM_CUSTOMERS-1:0]   r_done;
    logic [CIW-1:0]             r_idx;
    logic                       r_progress;

    // Output register.
    logic                       r_out_vld;
    bra_pkg::t_status           r_out_status;
    t_row                       r_out_avail;

    logic                       rd_en;
    logic [CIW-1:0]             rd_addr;
    logic [CIW-1:0]             cust_addr;
    logic [CIW-1:0]             idx_next;
    logic                       wr_en;
    t_row                       wr_data;
    t_row                       rd_eff;
    t_row                       need;
    t_row                       row_plus;
    logic                       over_need;
    logic                       over_avail;
    logic                       fit_res;
    logic                       fits;
    logic                       wrap;
    logic                       progress_next;
    logic [NUM_CUSTOMERS-1:0]   done_next;
    logic                       all_done;
    logic [AMOUNT_WIDTH:0]      rel_sum [bra_pkg::RES_SLOTS];

    assign cust_addr = CIW'(r_cust);
    assign rd_eff    = r_rd_vld ? r_rd_row : '0;
    assign wrap      = (r_idx == CIW'(NUM_CUSTOMERS - 1));
    assign idx_next  = wrap ? '0 : r_idx + 1'b1;

    always_comb begin
        over_need  = 1'b0;
        over_avail = 1'b0;
        fit_res    = 1'b1;
        for (int r = 0; r < bra_pkg::RES_SLOTS; r++) begin
            need[r]     = (r_pool[r] > rd_eff[r]) ? (r_pool[r] - rd_eff[r]) : '0;
            row_plus[r] = rd_eff[r];
            rel_sum[r]  = {1'b0, r_avail[r]} + {1'b0, rd_eff[r]};
            if (r < NUM_RESOURCES) begin
                row_plus[r] = rd_eff[r] + r_amt[r];
                if (r_amt[r] > need[r]) begin
                    over_need = 1'b1;
                end
                if (r_amt[r] > r_avail[r]) begin
                    over_avail = 1'b1;
                end
                if (WW'(need[r]) > r_work[r]) begin
                    fit_res = 1'b0;
                end
            end
        end
    end

    always_comb begin
        fits               = fit_res && !r_done[r_idx];
        done_next          = r_done;
        done_next[r_idx]   = r_done[r_idx] | fits;
        all_done           = &done_next;
        progress_next      = r_progress | fits;
    end

    always_comb begin
        o_stat.is_restart  = (r_type inside {bra_pkg::REQ_RESTART, bra_pkg::REQ_RESTART_ALT});
        o_stat.is_release  = (r_type == bra_pkg::REQ_RELEASE);
        o_stat.cust_ok     = (32'(r_cust) < NUM_CUSTOMERS);
        o_stat.over_need   = over_need;
        o_stat.over_avail  = over_avail;
        o_stat.walk_safe   = all_done;
        o_stat.walk_unsafe = wrap && !progress_next && !all_done;
        o_stat.out_free    = !r_out_vld || i_out_ready;
    end

    // Memory port selection.
    always_comb begin
        rd_en = i_cmd.rd_cust | i_cmd.walk_init | i_cmd.walk_step;
        if (i_cmd.rd_cust) begin
            rd_addr = cust_addr;
        end else if (i_cmd.walk_init) begin
            rd_addr = '0;
        end else begin
            rd_addr = idx_next;
        end
        wr_en   = i_cmd.tentative | i_cmd.rollback;
        wr_data = i_cmd.tentative ? row_plus : r_old_row;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[cust_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_row <= mem[rd_addr];
            r_rd_vld <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.restart) begin
            r_valid <= '0;
        end else if (i_cmd.release_apply) begin
            r_valid[cust_addr] <= 1'b0;
        end else if (wr_en) begin
            r_valid[cust_addr] <= 1'b1;
        end
    end

    // Next available counts.
    always_comb begin
        n_avail = r_avail;
        for (int r = 0; r < bra_pkg::RES_SLOTS; r++) begin
            if (i_cmd.restart) begin
                n_avail[r] = r_pool[r];
            end else if (r < NUM_RESOURCES) begin
                if (i_cmd.release_apply) begin
                    n_avail[r] = rel_sum[r][AMOUNT_WIDTH] ? AMT_MAX
                                                          : rel_sum[r][AMOUNT_WIDTH-1:0];
                end else if (i_cmd.tentative) begin
                    n_avail[r] = r_avail[r] - r_amt[r];
                end else if (i_cmd.rollback) begin
                    n_avail[r] = r_avail[r] + r_amt[r];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < bra_pkg::RES_SLOTS; r++) begin
                r_pool[r]  <= AMOUNT_WIDTH'(bra_pkg::POOL_RESET);
                r_avail[r] <= AMOUNT_WIDTH'(bra_pkg::POOL_RESET);
            end
        end else begin
            r_avail <= n_avail;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bra_pkg::CFG_POOL_0: r_pool[0] <= i_cfg_data;
                    bra_pkg::CFG_POOL_1: r_pool[1] <= i_cfg_data;
                    bra_pkg::CFG_POOL_2: r_pool[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Request capture, rollback copy and safety walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_req_type;
            r_cust <= i_customer;
            r_amt  <= i_amount;
        end
        if (i_cmd.tentative) begin
            r_old_row <= rd_eff;
        end
        if (i_cmd.walk_init) begin
            for (int r = 0; r < bra_pkg::RES_SLOTS; r++) begin
                r_work[r] <= WW'(r_avail[r]);
            end
            r_done     <= '0;
            r_idx      <= '0;
            r_progress <= 1'b0;
        end else if (i_cmd.walk_step) begin
            if (fits) begin
                for (int r = 0; r < bra_pkg::RES_SLOTS; r++) begin
                    r_work[r] <= r_work[r] + WW'(rd_eff[r]);
                end
            end
            r_done     <= done_next;
            r_idx      <= idx_next;
            r_progress <= wrap ? 1'b0 : progress_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.status;
            for (int r = 0; r < bra_pkg::RES_SLOTS; r++) begin
                r_out_avail[r] <= (r < NUM_RESOURCES) ? r_avail[r] : '0;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_status = r_out_status;
    assign o_out_avail  = r_out_avail;

endmodule

FILE: rtl/bankers_resource_allocator_unit.sv
`timescale 1ns / 1ps

// Banker's deadlock-avoidance allocator. Each request on i_req either asks
// customer i_req.customer's units of up to three resources, releases all
// that the customer holds, or restarts the pools; exactly one response
// follows on o_rsp with a status and the available counts after the step.
// A customer's maximum claim is the pool size of each resource, written
// through the plain configuration port (index 0 to 2, reset 10 each). The
// block works on one request at a time. A restart, or a request or release
// that names a customer beyond the last one, is answered straight from
// decode, any other release or refused allocation after the table lookup,
// and an allocation that passes both checks after the safety walk, with a
// rollback of the grant when the walk finds the state unsafe. The walk
// makes at most NUM_CUSTOMERS squared customer checks (25 for five
// customers) and checks one customer row against the work vector per
// cycle, since the allocation memory has one read port. A new response
// is held back while the previous one is still waiting downstream. No
// clearing pass is needed after reset; per-customer valid bits stand for
// the cleared allocation table.
module bankers_resource_allocator_unit #(
    parameter int NUM_CUSTOMERS = 5,
    parameter int NUM_RESOURCES = 3,
    parameter int AMOUNT_WIDTH  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bra_req_if.sink                           i_req,
    bra_rsp_if.source                         o_rsp,
    input  logic                              i_cfg_we,
    input  logic [bra_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [AMOUNT_WIDTH-1:0]           i_cfg_data
);

    bra_pkg::t_dp_cmd  s_cmd;
    bra_pkg::t_dp_stat s_stat;

    logic [bra_pkg::RES_SLOTS-1:0][AMOUNT_WIDTH-1:0] s_amount;
    logic [bra_pkg::RES_SLOTS-1:0][AMOUNT_WIDTH-1:0] s_avail;

    // The request channel is ready only while the controller is idle; the
    // response sits in its own register, so a new request may be taken
    // while the previous response is still waiting downstream.
    assign i_req.ready = s_cmd.in_ready;
    assign s_amount    = {i_req.amount_2, i_req.amount_1, i_req.amount_0};

    // The controller sequences decode, table lookup, the safety walk and
    // any rollback.
    bra_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    // The datapath holds the pools, available counts, allocation memory,
    // work vector and the response register.
    bra_dp #(
        .NUM_CUSTOMERS (NUM_CUSTOMERS),
        .NUM_RESOURCES (NUM_RESOURCES),
        .AMOUNT_WIDTH  (AMOUNT_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_stat       (s_stat),
        .i_req_type   (i_req.req_type),
        .i_customer   (i_req.customer),
        .i_amount     (s_amount),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_out_status (o_rsp.status),
        .o_out_avail  (s_avail)
    );

    assign o_rsp.avail_0 = s_avail[0];
    assign o_rsp.avail_1 = s_avail[1];
    assign o_rsp.avail_2 = s_avail[2];

`ifndef SYNTHESIS
    // Every request passes through decode before a response can be loaded.
    a_no_early_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !s_cmd.load_out)
        else $error("response loaded in the cycle after a request was accepted");

    // A response is only loaded when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load_out |-> s_stat.out_free)
        else $error("response loaded over one still waiting");

    // A loaded response is presented in the following cycle.
    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.load_out |=> o_rsp.valid)
        else $error("loaded response not presented");

    // A rollback only follows a walk that ended unsafe.
    a_rollback_after_unsafe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.rollback |-> $past(s_stat.walk_unsafe && s_cmd.walk_step))
        else $error("rollback without an unsafe walk");
`endif

endmodule
